// ----- sv/pic_pkg.sv -----
// Shared types, constants and the arithmetic program of the item correlation block.
package pic_pkg;

    localparam int RATING_W        = 8;
    localparam int CNT_W           = 17;
    localparam int SUM_W           = 24;
    localparam int SQ_W            = 33;
    localparam int ACC_W           = 72;
    localparam int PROD_W          = 2 * ACC_W;
    localparam int LIMB_W          = 24;
    localparam int LIMBS           = ACC_W / LIMB_W;
    localparam int QUO_W           = 32;
    localparam int ROOT_W          = QUO_W / 2;
    localparam int RMD_W           = ROOT_W + 3;
    localparam int STEP_W          = $clog2(QUO_W);
    localparam int CORR_W          = 16;
    localparam int PROG_LEN        = 22;
    localparam int PC_W            = $clog2(PROG_LEN);
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [CORR_W-1:0] CORR_MAX = 16'h7FFF;
    localparam logic [CORR_W-1:0] K_SAT    = 16'h8000;

    typedef struct packed {
        logic [CNT_W-1:0] count_first;
        logic [SUM_W-1:0] sum_first;
        logic [CNT_W-1:0] count_second;
        logic [SUM_W-1:0] sum_second;
        logic [CNT_W-1:0] count_both;
        logic [SUM_W-1:0] both_sum_first;
        logic [SUM_W-1:0] both_sum_second;
        logic [SQ_W-1:0]  both_square_first;
        logic [SQ_W-1:0]  both_square_second;
        logic [SQ_W-1:0]  both_cross;
    } sums_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_CHECK, ST_DIV, ST_SQRT, ST_DONE
    } back_state_t;

    typedef enum logic [3:0] {
        SRC_N1, SRC_N2, SRC_S1, SRC_S2, SRC_NB, SRC_B1, SRC_B2,
        SRC_Q1, SRC_Q2, SRC_C, SRC_TMP, SRC_MAG, SRC_A1, SRC_A2
    } src_t;

    typedef enum logic [3:0] {
        DST_TMP, DST_NUM_ADD, DST_NUM_SUB, DST_A1_ADD, DST_A1_SUB2,
        DST_A2_ADD, DST_A2_SUB2, DST_SQ, DST_PROD
    } dst_t;

    typedef struct packed {
        src_t src_a;
        src_t src_b;
        dst_t dst;
    } uop_t;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:    u = '{SRC_N1,  SRC_N2,  DST_TMP};
            5'd1:    u = '{SRC_TMP, SRC_C,   DST_NUM_ADD};
            5'd2:    u = '{SRC_N1,  SRC_S2,  DST_TMP};
            5'd3:    u = '{SRC_TMP, SRC_B1,  DST_NUM_SUB};
            5'd4:    u = '{SRC_N2,  SRC_S1,  DST_TMP};
            5'd5:    u = '{SRC_TMP, SRC_B2,  DST_NUM_SUB};
            5'd6:    u = '{SRC_NB,  SRC_S1,  DST_TMP};
            5'd7:    u = '{SRC_TMP, SRC_S2,  DST_NUM_ADD};
            5'd8:    u = '{SRC_N1,  SRC_N1,  DST_TMP};
            5'd9:    u = '{SRC_TMP, SRC_Q1,  DST_A1_ADD};
            5'd10:   u = '{SRC_N1,  SRC_S1,  DST_TMP};
            5'd11:   u = '{SRC_TMP, SRC_B1,  DST_A1_SUB2};
            5'd12:   u = '{SRC_NB,  SRC_S1,  DST_TMP};
            5'd13:   u = '{SRC_TMP, SRC_S1,  DST_A1_ADD};
            5'd14:   u = '{SRC_N2,  SRC_N2,  DST_TMP};
            5'd15:   u = '{SRC_TMP, SRC_Q2,  DST_A2_ADD};
            5'd16:   u = '{SRC_N2,  SRC_S2,  DST_TMP};
            5'd17:   u = '{SRC_TMP, SRC_B2,  DST_A2_SUB2};
            5'd18:   u = '{SRC_NB,  SRC_S2,  DST_TMP};
            5'd19:   u = '{SRC_TMP, SRC_S2,  DST_A2_ADD};
            5'd20:   u = '{SRC_MAG, SRC_MAG, DST_SQ};
            5'd21:   u = '{SRC_A1,  SRC_A2,  DST_PROD};
            default: u = '{SRC_N1,  SRC_N1,  DST_TMP};
        endcase
        return u;
    endfunction

endpackage

// ----- sv/pic_front.sv -----
// Front end: accepts rating pairs and keeps the running integer sums.
module pic_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [7:0] rating_first, [15:8] rating_second
    input  logic                 s_tlast,   // last_user
    output logic                 push_valid,
    input  logic                 push_ready,
    output pic_pkg::sums_t       push_data
);
    import pic_pkg::*;

    sums_t                 sums_reg, sums_next, upd;
    logic [RATING_W-1:0]   x, y;
    logic [2*RATING_W-1:0] sq_x, sq_y, xy;
    logic                  x_nz, y_nz, accept;

    assign x      = s_tdata[RATING_W-1:0];
    assign y      = s_tdata[2*RATING_W-1:RATING_W];
    assign x_nz   = x != '0;
    assign y_nz   = y != '0;
    assign sq_x   = x * x;
    assign sq_y   = y * y;
    assign xy     = x * y;
    assign accept = s_tvalid && s_tready;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && s_tlast;
    assign push_data  = upd;

    always_comb begin
        upd = sums_reg;
        if (x_nz) begin
            upd.count_first = sums_reg.count_first + 1'b1;
            upd.sum_first   = sums_reg.sum_first + SUM_W'(x);
        end
        if (y_nz) begin
            upd.count_second = sums_reg.count_second + 1'b1;
            upd.sum_second   = sums_reg.sum_second + SUM_W'(y);
        end
        if (x_nz && y_nz) begin
            upd.count_both         = sums_reg.count_both + 1'b1;
            upd.both_sum_first     = sums_reg.both_sum_first + SUM_W'(x);
            upd.both_sum_second    = sums_reg.both_sum_second + SUM_W'(y);
            upd.both_square_first  = sums_reg.both_square_first + SQ_W'(sq_x);
            upd.both_square_second = sums_reg.both_square_second + SQ_W'(sq_y);
            upd.both_cross         = sums_reg.both_cross + SQ_W'(xy);
        end
        sums_next = sums_reg;
        if (accept) begin
            sums_next = s_tlast ? '0 : upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_reg <= '0;
        end else begin
            sums_reg <= sums_next;
        end
    end

endmodule

// ----- sv/pic_queue.sv -----
// Short queue of finished sum sets between the front end and the arithmetic back end.
module pic_queue #(
    parameter int DEPTH = pic_pkg::DEF_QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  pic_pkg::sums_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output pic_pkg::sums_t pop_data
);
    import pic_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sums_t           entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            do_push, do_pop;

    assign push_ready = fill_reg != CW'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/pic_mul.sv -----
// Multicycle wide multiplier: one limb-by-limb partial product per cycle.
module pic_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  pic_pkg::mul_req_t req,
    output pic_pkg::mul_rsp_t rsp
);
    import pic_pkg::*;

    localparam int IDX_W = $clog2(LIMBS);
    localparam int SH_W  = $clog2(2 * LIMBS - 1);

    logic [ACC_W-1:0]    a_reg, a_next, b_reg, b_next;
    logic [IDX_W-1:0]    i_reg, i_next, j_reg, j_next;
    logic                issuing_reg, issuing_next, pv_reg, done_reg;
    logic [2*LIMB_W-1:0] pp_reg, pp_next;
    logic [SH_W-1:0]     sh_reg, sh_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [LIMB_W-1:0]   a_limb, b_limb;

    assign a_limb      = a_reg[i_reg*LIMB_W +: LIMB_W];
    assign b_limb      = b_reg[j_reg*LIMB_W +: LIMB_W];
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    always_comb begin
        a_next       = a_reg;
        b_next       = b_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        issuing_next = issuing_reg;
        pp_next      = pp_reg;
        sh_next      = sh_reg;
        acc_next     = acc_reg;
        if (req.start) begin
            a_next       = req.a;
            b_next       = req.b;
            i_next       = '0;
            j_next       = '0;
            issuing_next = 1'b1;
            acc_next     = '0;
        end else begin
            if (issuing_reg) begin
                pp_next = a_limb * b_limb;
                sh_next = SH_W'(i_reg) + SH_W'(j_reg);
                if (j_reg == IDX_W'(LIMBS - 1)) begin
                    j_next = '0;
                    if (i_reg == IDX_W'(LIMBS - 1)) begin
                        issuing_next = 1'b0;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            if (pv_reg) begin
                acc_next = acc_reg + (PROD_W'(pp_reg) << (sh_reg * LIMB_W));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg <= 1'b0;
            pv_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            issuing_reg <= issuing_next;
            pv_reg      <= issuing_reg;
            done_reg    <= pv_reg && !issuing_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

endmodule

// ----- sv/pic_back.sv -----
// Back end: forms numerator and variance terms, divides, takes the root, holds the result.
module pic_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  pic_pkg::sums_t    pop_data,
    output pic_pkg::mul_req_t mul_req,
    input  pic_pkg::mul_rsp_t mul_rsp,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,  // [15:0] correlation
    output logic              m_tuser   // undefined
);
    import pic_pkg::*;

    back_state_t        state_reg, state_next;
    sums_t              ent_reg, ent_next;
    logic [ACC_W-1:0]   num_reg, num_next, a1_reg, a1_next, a2_reg, a2_next;
    logic [ACC_W-1:0]   tmp_reg, tmp_next;
    logic [PROD_W-1:0]  sq_reg, sq_next, prod_reg, prod_next, rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [RMD_W-1:0]   remd_reg, remd_next;
    logic [CORR_W-1:0]  k_reg, k_next;
    logic               undef_reg, undef_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               m_tvalid_reg, m_tvalid_next, m_tuser_reg, m_tuser_next;
    logic [CORR_W-1:0]  m_tdata_reg, m_tdata_next;

    uop_t               uop;
    logic [ACC_W-1:0]   mag, p72;
    logic [PROD_W:0]    rem2;
    logic               div_ge, sq_ge, a1_pos, a2_pos, out_free, neg;
    logic [RMD_W-1:0]   sq_sh, trial, remd_step;
    logic [ROOT_W-1:0]  root_step;
    logic [CORR_W-1:0]  corr;

    function automatic logic [ACC_W-1:0] src_mux(input src_t s, input sums_t e,
                                                 input logic [ACC_W-1:0] t,
                                                 input logic [ACC_W-1:0] m,
                                                 input logic [ACC_W-1:0] v1,
                                                 input logic [ACC_W-1:0] v2);
        logic [ACC_W-1:0] r;
        unique case (s)
            SRC_N1:  r = ACC_W'(e.count_first);
            SRC_N2:  r = ACC_W'(e.count_second);
            SRC_S1:  r = ACC_W'(e.sum_first);
            SRC_S2:  r = ACC_W'(e.sum_second);
            SRC_NB:  r = ACC_W'(e.count_both);
            SRC_B1:  r = ACC_W'(e.both_sum_first);
            SRC_B2:  r = ACC_W'(e.both_sum_second);
            SRC_Q1:  r = ACC_W'(e.both_square_first);
            SRC_Q2:  r = ACC_W'(e.both_square_second);
            SRC_C:   r = ACC_W'(e.both_cross);
            SRC_TMP: r = t;
            SRC_MAG: r = m;
            SRC_A1:  r = v1;
            SRC_A2:  r = v2;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign uop       = uop_rom(pc_reg);
    assign neg       = num_reg[ACC_W-1];
    assign mag       = neg ? (~num_reg + 1'b1) : num_reg;
    assign p72       = mul_rsp.product[ACC_W-1:0];
    assign rem2      = {rem_reg, 1'b0};
    assign div_ge    = rem2 >= {1'b0, prod_reg};
    assign sq_ge     = sq_reg >= prod_reg;
    assign a1_pos    = !a1_reg[ACC_W-1] && (a1_reg != '0);
    assign a2_pos    = !a2_reg[ACC_W-1] && (a2_reg != '0);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign sq_sh     = {remd_reg[RMD_W-3:0], quo_reg[QUO_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign remd_step = (sq_sh >= trial) ? (sq_sh - trial) : sq_sh;
    assign root_step = {root_reg[ROOT_W-2:0], sq_sh >= trial};
    assign corr      = (neg && !undef_reg) ? (~k_reg + 1'b1)
                     : ((k_reg > CORR_MAX) ? CORR_MAX : k_reg);

    assign pop_ready     = state_reg == ST_IDLE;
    assign mul_req.start = state_reg == ST_ISSUE;
    assign mul_req.a     = src_mux(uop.src_a, ent_reg, tmp_reg, mag, a1_reg, a2_reg);
    assign mul_req.b     = src_mux(uop.src_b, ent_reg, tmp_reg, mag, a1_reg, a2_reg);
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;

    always_comb begin
        state_next    = state_reg;
        ent_next      = ent_reg;
        num_next      = num_reg;
        a1_next       = a1_reg;
        a2_next       = a2_reg;
        tmp_next      = tmp_reg;
        sq_next       = sq_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        root_next     = root_reg;
        remd_next     = remd_reg;
        k_next        = k_reg;
        undef_next    = undef_reg;
        pc_next       = pc_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    ent_next   = pop_data;
                    num_next   = '0;
                    a1_next    = '0;
                    a2_next    = '0;
                    pc_next    = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_rsp.done) begin
                    unique case (uop.dst)
                        DST_TMP:     tmp_next  = p72;
                        DST_NUM_ADD: num_next  = num_reg + p72;
                        DST_NUM_SUB: num_next  = num_reg - p72;
                        DST_A1_ADD:  a1_next   = a1_reg + p72;
                        DST_A1_SUB2: a1_next   = a1_reg - {p72[ACC_W-2:0], 1'b0};
                        DST_A2_ADD:  a2_next   = a2_reg + p72;
                        DST_A2_SUB2: a2_next   = a2_reg - {p72[ACC_W-2:0], 1'b0};
                        DST_SQ:      sq_next   = mul_rsp.product;
                        DST_PROD:    prod_next = mul_rsp.product;
                        default:     tmp_next  = tmp_reg;
                    endcase
                    if (pc_reg == PC_W'(PROG_LEN - 1)) begin
                        state_next = ST_CHECK;
                    end else begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_CHECK: begin
                undef_next = (ent_reg.count_first == '0) || (ent_reg.count_second == '0)
                           || !a1_pos || !a2_pos;
                if (undef_next) begin
                    k_next     = '0;
                    state_next = ST_DONE;
                end else if (sq_ge) begin
                    k_next     = K_SAT;
                    state_next = ST_DONE;
                end else begin
                    rem_next   = sq_reg;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = div_ge ? PROD_W'(rem2 - {1'b0, prod_reg}) : rem2[PROD_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], div_ge};
                if (cnt_reg == STEP_W'(QUO_W - 1)) begin
                    cnt_next   = '0;
                    root_next  = '0;
                    remd_next  = '0;
                    state_next = ST_SQRT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                remd_next = remd_step;
                root_next = root_step;
                quo_next  = {quo_reg[QUO_W-3:0], 2'b00};
                if (cnt_reg == STEP_W'(ROOT_W - 1)) begin
                    k_next     = CORR_W'(({1'b0, root_step} + 1'b1) >> 1);
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = corr;
                    m_tuser_next  = undef_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg     <= ent_next;
        num_reg     <= num_next;
        a1_reg      <= a1_next;
        a2_reg      <= a2_next;
        tmp_reg     <= tmp_next;
        sq_reg      <= sq_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        root_reg    <= root_next;
        remd_reg    <= remd_next;
        k_reg       <= k_next;
        undef_reg   <= undef_next;
        pc_reg      <= pc_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> state_reg == ST_WAIT)
        else $error("multiplier finished outside of the wait state");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < prod_reg)
        else $error("division remainder not below divisor");

    a_pop_starts_program: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |=> (state_reg == ST_ISSUE && pc_reg == '0))
        else $error("dequeued transaction did not start the program");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> k_reg <= K_SAT)
        else $error("correlation magnitude out of range");

    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> m_tdata_reg == '0)
        else $error("undefined result with nonzero correlation");

endmodule

// ----- sv/pearson_item_correlation_top.sv -----
// Top level of the Pearson item-item correlation block.
// Rating pairs stream in one per cycle; every pair updates exact integer
// sums, and a pair marked with s_tlast closes the run and hands the sum set
// to a queue of QUEUE_DEPTH entries. The back end then forms the numerator
// and both variance terms, divides and takes the square root to give a Q1.15
// correlation rounded to nearest (+1.0 reads as 32767), with m_tuser set when
// the result is undefined. In the back end a closing pair is worked through
// the 22 wide products that share one 24x24 multiplier, a 32-step divider
// and a 16-step square root; an undefined or full-scale result skips the
// divider and the root. Input stalls only while the queue is full.
module pearson_item_correlation_top #(
    parameter int QUEUE_DEPTH = pic_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rating_first, [15:8] rating_second
    input  logic        s_tlast,   // last_user
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] correlation
    output logic        m_tuser    // undefined
);
    import pic_pkg::*;

    sums_t    push_data, pop_data;
    logic     push_valid, push_ready, pop_valid, pop_ready;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    pic_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pic_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pic_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    pic_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- test/pearson_item_correlation_top_tb.sv -----
// Testbench for the Pearson item-item correlation block: directed and random rating runs.
module pearson_item_correlation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pic_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 800;
    localparam int RANDOM_PAIRS   = 1050;

    typedef logic [255:0] wide_t;

    typedef struct {
        logic [CORR_W-1:0] corr;
        logic              undef;
    } corr_result_t;

    typedef struct {
        logic [7:0]        first;
        logic [7:0]        second;
        logic              last;
        logic              typed;
        logic [CORR_W-1:0] corr;
        logic              undef;
    } pair_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    sums_t        sums;
    corr_result_t pending_corr[$];
    int           errors;
    int           idle_cycles;
    bit           gaps_on;

    pearson_item_correlation_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic corr_result_t correlate(input sums_t acc);
        corr_result_t res;
        wide_t n1, n2, s1, s2, nb, b1, b2, q1, q2, c;
        wide_t num, a1, a2, mag, prod, lhs, t;
        logic  neg;
        int    lo, hi, mid;
        n1 = acc.count_first;        n2 = acc.count_second;
        s1 = acc.sum_first;          s2 = acc.sum_second;
        nb = acc.count_both;         b1 = acc.both_sum_first;
        b2 = acc.both_sum_second;    q1 = acc.both_square_first;
        q2 = acc.both_square_second; c  = acc.both_cross;
        num = n1 * n2 * c - n1 * s2 * b1 - n2 * s1 * b2 + nb * s1 * s2;
        a1 = n1 * n1 * q1 - wide_t'(2) * n1 * s1 * b1 + nb * s1 * s1;
        a2 = n2 * n2 * q2 - wide_t'(2) * n2 * s2 * b2 + nb * s2 * s2;
        res.corr  = '0;
        res.undef = 1'b1;
        if (n1 == 0 || n2 == 0 || a1[255] || a1 == 0 || a2[255] || a2 == 0)
            return res;
        neg  = num[255];
        mag  = neg ? -num : num;
        prod = a1 * a2;
        lhs  = mag << 16;
        lhs  = lhs * lhs;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = wide_t'(2 * mid - 1);
            if (t * t * prod <= lhs) lo = mid;
            else hi = mid - 1;
        end
        res.undef = 1'b0;
        if (neg) res.corr = 16'(65536 - lo);
        else res.corr = (lo > 32767) ? CORR_MAX : 16'(lo);
        return res;
    endfunction

    // fold one accepted pair into the running sums; returns 1 when a result is due
    function automatic bit accumulate(input logic [7:0] x, input logic [7:0] y,
                                      input logic last, output corr_result_t res);
        if (x != 0) begin
            sums.count_first = sums.count_first + 1;
            sums.sum_first   = sums.sum_first + x;
        end
        if (y != 0) begin
            sums.count_second = sums.count_second + 1;
            sums.sum_second   = sums.sum_second + y;
        end
        if (x != 0 && y != 0) begin
            sums.count_both         = sums.count_both + 1;
            sums.both_sum_first     = sums.both_sum_first + x;
            sums.both_sum_second    = sums.both_sum_second + y;
            sums.both_square_first  = sums.both_square_first + SQ_W'(x) * SQ_W'(x);
            sums.both_square_second = sums.both_square_second + SQ_W'(y) * SQ_W'(y);
            sums.both_cross         = sums.both_cross + SQ_W'(x) * SQ_W'(y);
        end
        if (!last) return 0;
        res  = correlate(sums);
        sums = '0;
        return 1;
    endfunction

    task automatic send_pair(input logic [7:0] x, input logic [7:0] y, input logic last,
                             input bit typed, input corr_result_t typed_res);
        int           gap;
        corr_result_t res;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {y, x};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (accumulate(x, y, last, res)) begin
            if (typed) res = typed_res;
            pending_corr.insert(pending_corr.size(), res);
        end
        @(negedge aclk);
    endtask

    task automatic send_random_pair(input int style, input logic last);
        logic [7:0]   x, y;
        corr_result_t none;
        none = '{corr: '0, undef: 1'b0};
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
        if (style == 1) begin
            x = $urandom_range(1, 200);
            y = 8'(x + $urandom_range(0, 40));
        end else if (style == 2) begin
            x = $urandom_range(1, 250);
            y = 8'(255 - x + $urandom_range(0, 5));
        end
        if ($urandom_range(0, 4) == 0) x = '0;
        if ($urandom_range(0, 4) == 0) y = '0;
        send_pair(x, y, last, 0, none);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= gaps_on ? ($urandom_range(0, 4) == 0) : 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && (s_tvalid && s_tready || m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("pearson_item_correlation_top test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        corr_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_corr.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction corr=%h undef=%b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = pending_corr.pop_front();
                if (m_tdata !== want.corr) begin
                    errors++;
                    $display("%0t: correlation expected %h actual %h",
                             $time, want.corr, m_tdata);
                end
                if (m_tuser !== want.undef) begin
                    errors++;
                    $display("%0t: undefined expected %b actual %b",
                             $time, want.undef, m_tuser);
                end
            end
        end
    end

    pair_row_t directed[] = '{
        '{8'd0,   8'd0,   1'b1, 1'b1, 16'h0000, 1'b1},
        '{8'd1,   8'd1,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd2,   8'd2,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd3,   8'd3,   1'b1, 1'b1, 16'h7FFF, 1'b0},
        '{8'd1,   8'd3,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd2,   8'd2,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd3,   8'd1,   1'b1, 1'b1, 16'h8000, 1'b0},
        '{8'd255, 8'd0,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd0,   8'd255, 1'b1, 1'b1, 16'h0000, 1'b1},
        '{8'd5,   8'd5,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd5,   8'd9,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd5,   8'd1,   1'b1, 1'b1, 16'h0000, 1'b1},
        '{8'd255, 8'd1,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd1,   8'd255, 1'b1, 1'b1, 16'h8000, 1'b0},
        '{8'd255, 8'd255, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd1,   8'd1,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd255, 8'd1,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd1,   8'd255, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{8'd200, 8'd0,   1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd0,   8'd100, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd17,  8'd250, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd128, 8'd64,  1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'd90,  8'd90,  1'b1, 1'b0, 16'h0000, 1'b0},
        '{8'd7,   8'd7,   1'b1, 1'b1, 16'h0000, 1'b1}
    };

    initial begin
        int           sent, len, style, i;
        corr_result_t typed_res;
        errors      = 0;
        idle_cycles = 0;
        gaps_on     = 1'b1;
        sums        = '0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[k]) begin
            typed_res = '{corr: directed[k].corr, undef: directed[k].undef};
            send_pair(directed[k].first, directed[k].second, directed[k].last,
                      directed[k].typed, typed_res);
        end

        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            gaps_on = ($urandom_range(0, 5) != 0);
            style   = $urandom_range(0, 2);
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
            for (i = 0; i < len; i++) send_random_pair(style, i == len - 1);
            sent += len;
            if ($urandom_range(0, 15) == 0) begin
                s_tvalid <= 1'b0;
                while (pending_corr.size() != 0) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_corr.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0 && pending_corr.size() == 0)
            $display("pearson_item_correlation_top test passed");
        else
            $display("pearson_item_correlation_top test failed");
        $finish;
    end

endmodule
